[hdl/chorus_pkg.sv]
// ----------------------------------------------------------------------------
// chorus_pkg
// Shared sizes, register indexes, reset values and the LFO sine function of
// the stereo chorus.
// ----------------------------------------------------------------------------
package chorus_pkg;

   // Delay line length; must be a power of two.
   localparam int LINE_DEPTH   = 8192;
   localparam int SAMPLE_BITS  = 24;
   localparam int SINE_ENTRIES = 1024;

   localparam int PTR_BITS  = $clog2(LINE_DEPTH);
   localparam int SINE_BITS = $clog2(SINE_ENTRIES);

   // Delay arithmetic runs signed, wide enough for base plus a negative swing
   // and for the largest line index.
   localparam int DLY_W = (PTR_BITS + 2 > 16) ? PTR_BITS + 2 : 16;

   localparam int PHASE_BITS = 32;
   localparam int BASE_BITS  = 13;
   localparam int SPAN_BITS  = 13;
   localparam int MIX_BITS   = 16;
   localparam int CSR_BITS   = 32;
   localparam int IDX_BITS   = 2;

   typedef enum logic [IDX_BITS-1:0] {
      REG_PHASE_STEP = 2'd0,
      REG_BASE_DELAY = 2'd1,
      REG_DEPTH_SPAN = 2'd2,
      REG_MIX_LEVEL  = 2'd3
   } reg_index_type;

   localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = 32'd223696;
   localparam logic [BASE_BITS-1:0]  BASE_DELAY_RESET = 13'd960;
   localparam logic [SPAN_BITS-1:0]  DEPTH_SPAN_RESET = 13'd240;
   localparam logic [MIX_BITS-1:0]   MIX_LEVEL_RESET  = 16'd16384;

   // Q15 unity for the wet/dry blend.
   localparam logic [MIX_BITS:0] MIX_ONE = 17'd32768;

   // Q30 constants used to build the sine table at elaboration.
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] Q30_PI      = 64'd3373259426;
   localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
   localparam logic [63:0] SINE_PEAK   = 64'd32767;

   // One table entry: the angle is folded into the first quadrant and an odd
   // Taylor series up to x^11 is evaluated in Horner form with truncation.
   function automatic logic signed [15:0] sine_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] e;
      logic        neg;
      x   = (64'(k) * Q30_TWO_PI) / SINE_ENTRIES;
      neg = 1'b0;
      if (x >= Q30_PI) begin
         x   = x - Q30_PI;
         neg = 1'b1;
      end
      if (x > Q30_HALF_PI) begin
         x = Q30_PI - x;
      end
      x2 = (x * x) >> 30;
      t  = Q30_ONE - ((x2 * Q30_ONE) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      e  = (s * SINE_PEAK + (Q30_ONE >> 1)) >> 30;
      if (e > SINE_PEAK) begin
         e = SINE_PEAK;
      end
      return neg ? -$signed(e[15:0]) : $signed(e[15:0]);
   endfunction

endpackage

[hdl/chorus_ram.sv]
// ----------------------------------------------------------------------------
// chorus_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module chorus_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/chorus_sine_rom.sv]
// ----------------------------------------------------------------------------
// chorus_sine_rom
// Full-wave Q1.15 sine lookup for the LFO with a registered read.
// ----------------------------------------------------------------------------
module chorus_sine_rom (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [chorus_pkg::SINE_BITS-1:0] index,
   output logic signed [15:0]              sine
);
   import chorus_pkg::*;

   logic signed [15:0] rom_data [SINE_ENTRIES];
   logic signed [15:0] sine_ff;

   // Every entry is a constant worked out at elaboration.
   for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_entry
      localparam logic signed [15:0] ENTRY = sine_entry(k);
      assign rom_data[k] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sine_ff <= rom_data[index];
      end
   end

   assign sine = sine_ff;

endmodule

[hdl/stereo_chorus_lfo_delay.sv]
// ----------------------------------------------------------------------------
// stereo_chorus_lfo_delay
// Stereo chorus: two sine-modulated circular delay lines with a wet/dry blend.
// ----------------------------------------------------------------------------
// Each accepted request carries one stereo sample pair and yields exactly one
// mixed pair. The block works on one request at a time, in order: acceptance
// (line write and LFO table read), the sine times depth product, the delay
// clamp and delay line read, the four blend multiplies and the sum.
// These steps run in sequence through the single read port of the delay line
// memory. The result sits in an output register, so a new request is taken
// while the previous result still waits on rsp_stall; only when the final
// step finds that register still full does the sequencer hold. Both channels
// share one memory of LINE_DEPTH words, left sample in each word's upper half. The
// memory is never swept after reset: a fill flag and the write pointer tell
// which entries were written since reset, and entries not yet written read
// as zero, so the block is ready in the first cycle after reset. Delay is
// base_delay plus floor(sine * depth_span / 2^15), clamped to the line length;
// a delay of zero returns the sample of the same request. A mix_level above
// 32768 acts as 32768. Registers are written on csr_wr_en and should only be
// written while no request is in flight. LINE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module stereo_chorus_lfo_delay (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [chorus_pkg::SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [chorus_pkg::SAMPLE_BITS-1:0] req_right_in,
   // Result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [chorus_pkg::SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [chorus_pkg::SAMPLE_BITS-1:0] rsp_right_out,
   // Configuration write port
   input  logic                                   csr_wr_en,
   input  logic [chorus_pkg::IDX_BITS-1:0]         csr_index,
   input  logic [chorus_pkg::CSR_BITS-1:0]         csr_wdata
);
   import chorus_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + MIX_BITS + 2;
   localparam int SUM_W  = PROD_W + 1;
   localparam int LINE_W = 2 * SAMPLE_BITS;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PROD = 5'b00010,
      ST_ADDR = 5'b00100,
      ST_MULT = 5'b01000,
      ST_SUM  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic [BASE_BITS-1:0]  base_ff, base_in;
   logic [SPAN_BITS-1:0]  span_ff, span_in;
   logic [MIX_BITS-1:0]   mix_ff, mix_in;

   // Running state outside the memory.
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PTR_BITS-1:0]   wp_ff, wp_in;
   logic                  full_ff, full_in;

   // Per-request working registers.
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;
   logic signed [SAMPLE_BITS-1:0] right_ff, right_in;
   logic signed [29:0]            dprod_ff, dprod_in;
   logic                          line_ok_ff, line_ok_in;
   logic signed [PROD_W-1:0]      l_dry_ff, l_dry_in, l_wet_ff, l_wet_in;
   logic signed [PROD_W-1:0]      r_dry_ff, r_dry_in, r_wet_ff, r_wet_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;

   logic                          accept;
   logic                          out_free;
   logic                          finish;
   logic signed [15:0]            sine;
   logic [LINE_W-1:0]             line_rd_data;
   logic signed [DLY_W-1:0]       delay_raw;
   logic [PTR_BITS-1:0]           delay;
   logic [PTR_BITS-1:0]           rd_addr;
   logic signed [SAMPLE_BITS-1:0] l_delayed, r_delayed;
   logic [MIX_BITS:0]             wet, dry;
   logic signed [SUM_W-1:0]       l_sum, r_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_SUM) && out_free;

   // The LFO table is indexed by the top bits of the phase accumulator.
   chorus_sine_rom u_sine_rom (
      .clock (clock),
      .rd_en (accept),
      .index (phase_ff[PHASE_BITS-1 -: SINE_BITS]),
      .sine  (sine)
   );

   // Both channels live in one memory word. The new pair is written in the
   // acceptance cycle, ahead of the read in ST_ADDR, so a zero delay reads
   // back the sample just written without any bypass.
   chorus_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data ({req_left_in, req_right_in}),
      .rd_en   (state_ff == ST_ADDR),
      .rd_addr (rd_addr),
      .rd_data (line_rd_data)
   );

   // Delay from the registered sine product, clamped to the line.
   always_comb begin
      delay_raw = DLY_W'(signed'({1'b0, base_ff})) + DLY_W'(dprod_ff >>> 15);
      if (delay_raw < 0) begin
         delay = '0;
      end else if (delay_raw > DLY_W'(LINE_DEPTH - 1)) begin
         delay = PTR_BITS'(LINE_DEPTH - 1);
      end else begin
         delay = delay_raw[PTR_BITS-1:0];
      end
      rd_addr = wp_ff - delay;
   end

   // Blend weights and delayed samples. Before the line has wrapped once,
   // only entries up to the write pointer hold data; the rest read as zero.
   always_comb begin
      wet       = (mix_ff > MIX_ONE[MIX_BITS-1:0] && mix_ff != MIX_ONE[MIX_BITS-1:0])
                  ? MIX_ONE : {1'b0, mix_ff};
      dry       = MIX_ONE - wet;
      l_delayed = line_ok_ff ? signed'(line_rd_data[LINE_W-1 -: SAMPLE_BITS]) : '0;
      r_delayed = line_ok_ff ? signed'(line_rd_data[SAMPLE_BITS-1:0]) : '0;
      l_sum     = SUM_W'(l_dry_ff) + SUM_W'(l_wet_ff);
      r_sum     = SUM_W'(r_dry_ff) + SUM_W'(r_wet_ff);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      base_in      = base_ff;
      span_in      = span_ff;
      mix_in       = mix_ff;
      phase_in     = phase_ff;
      wp_in        = wp_ff;
      full_in      = full_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      dprod_in     = dprod_ff;
      line_ok_in   = line_ok_ff;
      l_dry_in     = l_dry_ff;
      l_wet_in     = l_wet_ff;
      r_dry_in     = r_dry_ff;
      r_wet_in     = r_wet_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_PHASE_STEP: step_in = csr_wdata[PHASE_BITS-1:0];
            REG_BASE_DELAY: base_in = csr_wdata[BASE_BITS-1:0];
            REG_DEPTH_SPAN: span_in = csr_wdata[SPAN_BITS-1:0];
            REG_MIX_LEVEL:  mix_in  = csr_wdata[MIX_BITS-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               left_in  = req_left_in;
               right_in = req_right_in;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            dprod_in = sine * signed'({1'b0, span_ff});
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            line_ok_in = full_ff || (rd_addr <= wp_ff);
            state_in   = ST_MULT;
         end
         ST_MULT: begin
            l_dry_in = left_ff * signed'({1'b0, dry});
            l_wet_in = l_delayed * signed'({1'b0, wet});
            r_dry_in = right_ff * signed'({1'b0, dry});
            r_wet_in = r_delayed * signed'({1'b0, wet});
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = SAMPLE_BITS'(l_sum >>> 15);
               rsp_right_in = SAMPLE_BITS'(r_sum >>> 15);
               phase_in     = phase_ff + step_ff;
               wp_in        = wp_ff + 1'b1;
               if (wp_ff == PTR_BITS'(LINE_DEPTH - 1)) begin
                  full_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= PHASE_STEP_RESET;
         base_ff      <= BASE_DELAY_RESET;
         span_ff      <= DEPTH_SPAN_RESET;
         mix_ff       <= MIX_LEVEL_RESET;
         phase_ff     <= '0;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         base_ff      <= base_in;
         span_ff      <= span_in;
         mix_ff       <= mix_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      dprod_ff     <= dprod_in;
      line_ok_ff   <= line_ok_in;
      l_dry_ff     <= l_dry_in;
      l_wet_ff     <= l_wet_in;
      r_dry_ff     <= r_dry_in;
      r_wet_ff     <= r_wet_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_PROD))
      else $error("accepted request did not start the sequencer");

   a_pointer_moves_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SUM) |=> $stable(wp_ff))
      else $error("write pointer moved outside request completion");

   a_full_sticks: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("line fill flag dropped");

   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_SUM))
      else $error("result left the sequencer while the output register was full");
`endif

endmodule

[tb/stereo_chorus_lfo_delay_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_chorus_lfo_delay_tb
// Self-checking testbench for the stereo chorus modulated delay line.
// ----------------------------------------------------------------------------
// A short directed table covers sample extremes, the fully wet, fully dry and
// over-range mix settings, zero delay and both ends of the delay clamp. Random
// requests then run through eight register settings under changing flow
// control on both channels. Each result is checked against its typed value or a
// predictor that keeps its own copy of the delay lines, the LFO and the registers.
// ----------------------------------------------------------------------------
module stereo_chorus_lfo_delay_tb;
   import chorus_pkg::*;

   localparam int SAMPLE_MAX      = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int SAMPLE_MIN      = -(1 << (SAMPLE_BITS - 1));
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int MAX_REPORTS     = 10;
   // Covers a request that is still in flight when the last result leaves.
   localparam int DRAIN_CYCLES    = 12;
   localparam int TIMEOUT_NS      = 10_000_000;

   // Q30 angles used to build the LFO waveform.
   localparam logic [63:0] ANGLE_ONE     = 64'd1073741824;
   localparam logic [63:0] ANGLE_HALF_PI = 64'd1686629713;
   localparam logic [63:0] ANGLE_PI      = 64'd3373259426;
   localparam logic [63:0] ANGLE_TWO_PI  = 64'd6746518852;
   localparam logic [63:0] WAVE_PEAK     = 64'd32767;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } stereo_pair_type;

   typedef enum logic {
      ROW_SETUP,
      ROW_SAMPLE
   } row_kind_type;

   // One line of the directed table: either a full set of register values or
   // one stereo request, with its result typed in when it is obvious.
   typedef struct packed {
      row_kind_type        kind;
      logic [CSR_BITS-1:0] step_data;
      logic [CSR_BITS-1:0] base_data;
      logic [CSR_BITS-1:0] span_data;
      logic [CSR_BITS-1:0] mix_data;
      stereo_pair_type     sample;
      logic                typed;
      stereo_pair_type     result;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   sample_type             req_left_in;
   sample_type             req_right_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   sample_type             rsp_left_out;
   sample_type             rsp_right_out;
   logic                   csr_wr_en;
   logic [IDX_BITS-1:0]    csr_index;
   logic [CSR_BITS-1:0]    csr_wdata;

   // Typed result travelling alongside the request payload.
   logic                   row_is_typed;
   stereo_pair_type        row_result;

   // Flow control: chance in percent of a sender gap or a receiver stall.
   int                     gap_pct;
   int                     stall_pct;
   int                     error_count;

   // Predictor state: delay lines, write pointer, LFO phase and registers.
   sample_type             left_history [LINE_DEPTH];
   sample_type             right_history [LINE_DEPTH];
   logic [PTR_BITS-1:0]    head_pos;
   logic [PHASE_BITS-1:0]  lfo_angle;
   logic [PHASE_BITS-1:0]  cfg_step;
   logic [BASE_BITS-1:0]   cfg_base;
   logic [SPAN_BITS-1:0]   cfg_span;
   logic [MIX_BITS-1:0]    cfg_mix;
   int                     lfo_wave [SINE_ENTRIES];

   // Mixed pairs still owed by the block, oldest first.
   stereo_pair_type        pending_pairs [$];

   stereo_chorus_lfo_delay i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #6 clock = ~clock;

   // One waveform entry, round(32767 * sin(2*pi*k/N)). The angle is folded
   // into the first quadrant and the odd Taylor series up to x^11 is taken in
   // Horner form, truncating after every product as the hardware table does.
   function automatic int lfo_wave_entry(input int unsigned k);
      logic [63:0] ang;
      logic [63:0] sq;
      logic [63:0] poly;
      logic [63:0] amp;
      logic        flip;
      ang  = (64'(k) * ANGLE_TWO_PI) / 64'(SINE_ENTRIES);
      flip = 1'b0;
      if (ang >= ANGLE_PI) begin
         ang  = ang - ANGLE_PI;
         flip = 1'b1;
      end
      if (ang > ANGLE_HALF_PI) begin
         ang = ANGLE_PI - ang;
      end
      sq   = (ang * ang) >> 30;
      poly = ANGLE_ONE - ((sq * ANGLE_ONE) >> 30) / 64'd110;
      poly = ANGLE_ONE - ((sq * poly) >> 30) / 64'd72;
      poly = ANGLE_ONE - ((sq * poly) >> 30) / 64'd42;
      poly = ANGLE_ONE - ((sq * poly) >> 30) / 64'd20;
      poly = ANGLE_ONE - ((sq * poly) >> 30) / 64'd6;
      amp  = ((((ang * poly) >> 30) * WAVE_PEAK) + (ANGLE_ONE >> 1)) >> 30;
      if (amp > WAVE_PEAK) begin
         amp = WAVE_PEAK;
      end
      return flip ? -int'(amp) : int'(amp);
   endfunction

   // Advances the predictor by one stereo request and returns the mixed pair.
   function automatic stereo_pair_type chorus_blend(input stereo_pair_type dry_in);
      longint              swing;
      longint              lag;
      longint              wet;
      longint              dry;
      longint              acc;
      logic [PTR_BITS-1:0] tap;
      stereo_pair_type     mixed;
      left_history[head_pos]  = dry_in.left;
      right_history[head_pos] = dry_in.right;
      // The top phase bits index the waveform; >>> floors the product.
      swing = (longint'(lfo_wave[lfo_angle[PHASE_BITS-1 -: SINE_BITS]])
               * longint'(cfg_span)) >>> 15;
      lfo_angle = lfo_angle + cfg_step;
      lag = longint'(cfg_base) + swing;
      if (lag < 0) begin
         lag = 0;
      end
      if (lag > LINE_DEPTH - 1) begin
         lag = LINE_DEPTH - 1;
      end
      // Zero delay reads back the sample written just above.
      tap = head_pos - lag[PTR_BITS-1:0];
      wet = (cfg_mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(cfg_mix);
      dry = longint'(MIX_ONE) - wet;
      acc = (longint'($signed(dry_in.left)) * dry
             + longint'($signed(left_history[tap])) * wet) >>> 15;
      mixed.left = acc[SAMPLE_BITS-1:0];
      acc = (longint'($signed(dry_in.right)) * dry
             + longint'($signed(right_history[tap])) * wet) >>> 15;
      mixed.right = acc[SAMPLE_BITS-1:0];
      head_pos = head_pos + 1'b1;
      return mixed;
   endfunction

   function automatic stim_row_type setup_row(input logic [CSR_BITS-1:0] step_data,
                                              input logic [CSR_BITS-1:0] base_data,
                                              input logic [CSR_BITS-1:0] span_data,
                                              input logic [CSR_BITS-1:0] mix_data);
      stim_row_type row;
      row           = '0;
      row.kind      = ROW_SETUP;
      row.step_data = step_data;
      row.base_data = base_data;
      row.span_data = span_data;
      row.mix_data  = mix_data;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input int left, input int right,
                                              input int want_left,
                                              input int want_right);
      stim_row_type row;
      row              = '0;
      row.kind         = ROW_SAMPLE;
      row.sample.left  = sample_type'(left);
      row.sample.right = sample_type'(right);
      row.typed        = 1'b1;
      row.result.left  = sample_type'(want_left);
      row.result.right = sample_type'(want_right);
      return row;
   endfunction

   function automatic stim_row_type checked_row(input int left, input int right);
      stim_row_type row;
      row              = '0;
      row.kind         = ROW_SAMPLE;
      row.sample.left  = sample_type'(left);
      row.sample.right = sample_type'(right);
      return row;
   endfunction

   // Mostly full-range noise, with the extremes and the values around zero
   // mixed in often enough to show up in every phase.
   function automatic sample_type random_sample();
      if ($urandom_range(99) < 85) begin
         return sample_type'($urandom);
      end
      case ($urandom_range(3))
         0:       return sample_type'(SAMPLE_MAX);
         1:       return sample_type'(SAMPLE_MIN);
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Short delays are favored so that most reads land on samples written in
   // this run rather than on the cleared part of the line.
   function automatic int unsigned random_lag();
      if ($urandom_range(99) < 70) begin
         return $urandom_range(300);
      end
      return $urandom_range(LINE_DEPTH - 1);
   endfunction

   // Fills the unused upper bits of a register write with noise.
   function automatic logic [CSR_BITS-1:0] pad_high(input int unsigned value, input int width);
      return (($urandom >> width) << width) | value;
   endfunction

   task automatic note_mismatch(input string what, input stereo_pair_type want,
                                input stereo_pair_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%s: expected left %0d right %0d, got left %0d right %0d", what,
                  $signed(want.left), $signed(want.right),
                  $signed(got.left), $signed(got.right));
      end
   endtask

   // Drops valid and waits until every owed result has come back and the
   // block has had time to settle.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pairs.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers on consecutive cycles once the block is idle.
   task automatic write_registers(input logic [CSR_BITS-1:0] step_data,
                                  input logic [CSR_BITS-1:0] base_data,
                                  input logic [CSR_BITS-1:0] span_data,
                                  input logic [CSR_BITS-1:0] mix_data);
      wait_for_idle();
      csr_wr_en <= 1'b1;
      csr_index <= REG_PHASE_STEP;
      csr_wdata <= step_data;
      @(posedge clock);
      csr_index <= REG_BASE_DELAY;
      csr_wdata <= base_data;
      @(posedge clock);
      csr_index <= REG_DEPTH_SPAN;
      csr_wdata <= span_data;
      @(posedge clock);
      csr_index <= REG_MIX_LEVEL;
      csr_wdata <= mix_data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Presents one request, after an optional random gap, and returns at the
   // edge where it is taken.
   task automatic send_pair(input stereo_pair_type pair, input logic typed,
                            input stereo_pair_type result);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid    <= 1'b1;
      req_left_in  <= pair.left;
      req_right_in <= pair.right;
      row_is_typed <= typed;
      row_result   <= result;
      do @(posedge clock); while (req_stall);
   endtask

   // The receiver stalls at random at the rate chosen for the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Register writes and accepted requests update the predictor at the edge
   // where the block sees them; accepted results are checked at theirs.
   always @(posedge clock) begin : watch_channels
      stereo_pair_type predicted;
      stereo_pair_type observed;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_PHASE_STEP: cfg_step = csr_wdata[PHASE_BITS-1:0];
               REG_BASE_DELAY: cfg_base = csr_wdata[BASE_BITS-1:0];
               REG_DEPTH_SPAN: cfg_span = csr_wdata[SPAN_BITS-1:0];
               REG_MIX_LEVEL:  cfg_mix  = csr_wdata[MIX_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted = chorus_blend({req_left_in, req_right_in});
            pending_pairs.push_back(row_is_typed ? row_result : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            observed = {rsp_left_out, rsp_right_out};
            if (pending_pairs.size() == 0) begin
               note_mismatch("result with no request outstanding", '0, observed);
            end else begin
               predicted = pending_pairs.pop_front();
               if (observed.left !== predicted.left || observed.right !== predicted.right) begin
                  note_mismatch("mixed pair differs", predicted, observed);
               end
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type directed [$];
      // Everything starts from known values, including the predictor, which
      // mirrors the cleared delay lines and the register reset values.
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_left_in  = '0;
      req_right_in = '0;
      rsp_stall    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = REG_PHASE_STEP;
      csr_wdata    = '0;
      row_is_typed = 1'b0;
      row_result   = '0;
      gap_pct      = 0;
      stall_pct    = 0;
      error_count  = 0;
      head_pos     = '0;
      lfo_angle    = '0;
      cfg_step     = PHASE_STEP_RESET;
      cfg_base     = BASE_DELAY_RESET;
      cfg_span     = DEPTH_SPAN_RESET;
      cfg_mix      = MIX_LEVEL_RESET;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         left_history[i]  = '0;
         right_history[i] = '0;
      end
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         lfo_wave[k] = lfo_wave_entry(k);
      end

      // Right after reset the LFO sits at zero, so the delay is the reset
      // base of 960 samples and lands on cleared memory. At half mix every
      // output is then the input halved, rounded toward minus infinity.
      directed.push_back(typed_row(SAMPLE_MAX, SAMPLE_MIN, 4194303, -4194304));
      directed.push_back(typed_row(-1, 1, -1, 0));
      directed.push_back(typed_row(0, 5592405, 0, 2796202));
      directed.push_back(typed_row(-5592406, 3, -2796203, 1));
      // No modulation and no base delay: the tap is the sample just written,
      // so a fully wet mix passes the input straight through.
      directed.push_back(setup_row(32'd0, 32'd0, 32'd0, 32'd32768));
      directed.push_back(typed_row(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));
      directed.push_back(typed_row(-1, 1, -1, 1));
      // A mix above unity acts as unity; the upper bits of the delay writes
      // fall outside the registers and leave both at zero.
      directed.push_back(setup_row(32'd0, 32'hFFFF_E000, 32'hFFFF_E000, 32'h0000_FFFF));
      directed.push_back(typed_row(1193046, -1193047, 1193046, -1193047));
      directed.push_back(typed_row(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
      // Fully dry mix returns the input whatever the delay does.
      directed.push_back(setup_row(32'hFFFF_FFFF, 32'd960, 32'd8191, 32'd0));
      directed.push_back(typed_row(SAMPLE_MAX, -1, SAMPLE_MAX, -1));
      directed.push_back(typed_row(7, SAMPLE_MIN, 7, SAMPLE_MIN));
      // Quarter-turn LFO steps with the largest base and span push the delay
      // past the end of the line, where it clamps.
      directed.push_back(setup_row(32'h4000_0000, 32'hFFFF_FFFF, 32'd8191, 32'd32768));
      directed.push_back(checked_row(12345, -54321));
      directed.push_back(checked_row(SAMPLE_MAX, SAMPLE_MIN));
      directed.push_back(checked_row(-2, 2));
      directed.push_back(checked_row(4660, -4660));
      // Zero base with the full span swings the delay below zero, where it
      // clamps to the current sample.
      directed.push_back(setup_row(32'h4000_0000, 32'd0, 32'd8191, 32'd20000));
      directed.push_back(checked_row(SAMPLE_MIN, SAMPLE_MAX));
      directed.push_back(checked_row(1000000, -1000000));
      directed.push_back(checked_row(-3, 3));
      directed.push_back(checked_row(8, -8));
      // A short, gently swept delay that reads back samples from above.
      directed.push_back(setup_row(32'h0400_0000, 32'd5, 32'd3, 32'd24576));
      directed.push_back(checked_row(111111, -222222));
      directed.push_back(checked_row(SAMPLE_MAX, SAMPLE_MAX));
      directed.push_back(checked_row(SAMPLE_MIN, SAMPLE_MIN));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_SETUP) begin
            write_registers(directed[i].step_data, directed[i].base_data,
                            directed[i].span_data, directed[i].mix_data);
         end else begin
            send_pair(directed[i].sample, directed[i].typed, directed[i].result);
         end
      end

      // Random part: each phase loads new registers while idle, then streams
      // requests under one of four flow-control patterns.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            // Every register at the top of its field.
            1: write_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            // Every register at zero.
            2: write_registers(32'd0, 32'd0, 32'd0, 32'd0);
            default: begin
               write_registers(($urandom_range(99) < 50) ? $urandom_range(1 << 26) : $urandom,
                               pad_high(random_lag(), BASE_BITS),
                               pad_high(random_lag(), SPAN_BITS),
                               pad_high(($urandom_range(99) < 80) ? $urandom_range(32768)
                                                                  : $urandom_range(65535, 32769),
                                        MIX_BITS));
            end
         endcase
         case (ph % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 47;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 47;
            end
            default: begin
               gap_pct   = 8;
               stall_pct = 8;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through one stalled phase the sender holds off until
            // the block has drained completely.
            if (ph == 6 && n == ITEMS_PER_PHASE / 2) begin
               wait_for_idle();
            end
            send_pair({random_sample(), random_sample()}, 1'b0, '0);
         end
      end

      wait_for_idle();
      if (error_count == 0) begin
         $display("[stereo_chorus_lfo_delay] OK");
      end else begin
         $display("[stereo_chorus_lfo_delay] ERROR");
      end
      $finish;
   end

   // Far beyond the slowest correct run; anything left waiting is a hang.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[stereo_chorus_lfo_delay] ERROR");
      $finish;
   end

endmodule
